FILE: src/rvenc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM encoder package
// Mnemonic codes, major opcodes, error codes, the operation class, the
// stage-two payload and the funct3/funct7 lookup functions.
// ----------------------------------------------------------------------------
package rvenc_pkg;

    // Mnemonic codes at the boundaries of each group and single mnemonics.
    localparam logic [5:0] OPC_ADD   = 6'd0;
    localparam logic [5:0] OPC_R_END = 6'd17;
    localparam logic [5:0] OPC_ADDI  = 6'd18;
    localparam logic [5:0] OPC_SLLI  = 6'd19;
    localparam logic [5:0] OPC_SRLI  = 6'd23;
    localparam logic [5:0] OPC_SRAI  = 6'd24;
    localparam logic [5:0] OPC_I_END = 6'd26;
    localparam logic [5:0] OPC_LB    = 6'd27;
    localparam logic [5:0] OPC_L_END = 6'd31;
    localparam logic [5:0] OPC_SB    = 6'd32;
    localparam logic [5:0] OPC_S_END = 6'd34;
    localparam logic [5:0] OPC_BEQ   = 6'd35;
    localparam logic [5:0] OPC_B_END = 6'd40;
    localparam logic [5:0] OPC_JAL   = 6'd41;
    localparam logic [5:0] OPC_JALR  = 6'd42;
    localparam logic [5:0] OPC_CALL  = 6'd43;
    localparam logic [5:0] OPC_TAIL  = 6'd44;
    localparam logic [5:0] OPC_LI    = 6'd45;
    localparam logic [5:0] OPC_LUI   = 6'd46;
    localparam logic [5:0] OPC_AUIPC = 6'd47;

    // Major opcodes of the instruction formats.
    localparam logic [6:0] MAJ_R      = 7'h33;
    localparam logic [6:0] MAJ_IMM    = 7'h13;
    localparam logic [6:0] MAJ_LOAD   = 7'h03;
    localparam logic [6:0] MAJ_STORE  = 7'h23;
    localparam logic [6:0] MAJ_BRANCH = 7'h63;
    localparam logic [6:0] MAJ_JAL    = 7'h6F;
    localparam logic [6:0] MAJ_JALR   = 7'h67;
    localparam logic [6:0] MAJ_LUI    = 7'h37;
    localparam logic [6:0] MAJ_AUIPC  = 7'h17;

    // Register numbers used by the call and tail expansions.
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_T1   = 5'd6;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ALIGN = 2'd2;

    typedef enum logic [3:0] {
        CLS_R      = 4'd0,
        CLS_IARITH = 4'd1,
        CLS_LOAD   = 4'd2,
        CLS_STORE  = 4'd3,
        CLS_BRANCH = 4'd4,
        CLS_JAL    = 4'd5,
        CLS_JALR   = 4'd6,
        CLS_CALL   = 4'd7,
        CLS_TAIL   = 4'd8,
        CLS_LI     = 4'd9,
        CLS_LUI    = 4'd10,
        CLS_AUIPC  = 4'd11
    } cls_t;

    // Payload handed from the check stage to the word assembly logic.
    typedef struct packed {
        cls_t        cls;
        logic [5:0]  opcode;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] disp;
        logic [19:0] hi;
        logic [11:0] lo;
        logic [1:0]  err;
    } s2_t;

    function automatic logic [2:0] r_funct3(input logic [4:0] k);
        logic [2:0] f;
        unique case (k)
            5'd0, 5'd1, 5'd10: f = 3'd0;
            5'd2, 5'd11:       f = 3'd1;
            5'd3, 5'd12:       f = 3'd2;
            5'd4, 5'd13:       f = 3'd3;
            5'd5, 5'd14:       f = 3'd4;
            5'd6, 5'd7, 5'd15: f = 3'd5;
            5'd8, 5'd16:       f = 3'd6;
            5'd9, 5'd17:       f = 3'd7;
            default:           f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [6:0] r_funct7(input logic [4:0] k);
        logic [6:0] f;
        if (k == 5'd1 || k == 5'd7) begin
            f = 7'h20;
        end else if (k >= 5'd10) begin
            f = 7'h01;
        end else begin
            f = 7'h00;
        end
        return f;
    endfunction

    function automatic logic [2:0] i_funct3(input logic [3:0] k);
        logic [2:0] f;
        unique case (k)
            4'd0:       f = 3'd0;
            4'd1:       f = 3'd1;
            4'd2:       f = 3'd2;
            4'd3:       f = 3'd3;
            4'd4:       f = 3'd4;
            4'd5, 4'd6: f = 3'd5;
            4'd7:       f = 3'd6;
            4'd8:       f = 3'd7;
            default:    f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] ld_funct3(input logic [2:0] k);
        logic [2:0] f;
        unique case (k)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd1;
            3'd2:    f = 3'd2;
            3'd3:    f = 3'd4;
            3'd4:    f = 3'd5;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] br_funct3(input logic [2:0] k);
        logic [2:0] f;
        unique case (k)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd1;
            3'd2:    f = 3'd4;
            3'd3:    f = 3'd5;
            3'd4:    f = 3'd6;
            3'd5:    f = 3'd7;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

FILE: src/rvenc_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM word assembly
// Packs the checked fields of one item into its first and second machine
// word. An item with an error gives a single zero word.
// ----------------------------------------------------------------------------
module rvenc_pack (
    input  rvenc_pkg::s2_t s2,
    output logic [31:0]    word0,
    output logic [31:0]    word1,
    output logic           two
);
    import rvenc_pkg::*;

    logic [5:0]  k_r;
    logic [5:0]  k_i;
    logic [5:0]  k_l;
    logic [5:0]  k_s;
    logic [5:0]  k_b;
    logic [31:0] enc0;
    logic [31:0] enc1;
    logic        pair;

    always_comb begin
        k_r  = s2.opcode - OPC_ADD;
        k_i  = s2.opcode - OPC_ADDI;
        k_l  = s2.opcode - OPC_LB;
        k_s  = s2.opcode - OPC_SB;
        k_b  = s2.opcode - OPC_BEQ;
        enc1 = '0;
        pair = 1'b0;
        unique case (s2.cls)
            CLS_R: begin
                enc0 = {r_funct7(k_r[4:0]), s2.rs2, s2.rs1, r_funct3(k_r[4:0]),
                        s2.rd, MAJ_R};
            end
            CLS_IARITH: begin
                enc0 = {s2.imm[11:0], s2.rs1, i_funct3(k_i[3:0]), s2.rd, MAJ_IMM};
            end
            CLS_LOAD: begin
                enc0 = {s2.imm[11:0], s2.rs1, ld_funct3(k_l[2:0]), s2.rd, MAJ_LOAD};
            end
            CLS_STORE: begin
                enc0 = {s2.imm[11:5], s2.rd, s2.rs1, k_s[2:0], s2.imm[4:0], MAJ_STORE};
            end
            CLS_BRANCH: begin
                enc0 = {s2.disp[12], s2.disp[10:5], s2.rs2, s2.rs1,
                        br_funct3(k_b[2:0]), s2.disp[4:1], s2.disp[11], MAJ_BRANCH};
            end
            CLS_JAL: begin
                enc0 = {s2.disp[20], s2.disp[10:1], s2.disp[11], s2.disp[19:12],
                        s2.rd, MAJ_JAL};
            end
            CLS_JALR: begin
                enc0 = {s2.imm[11:0], s2.rs1, 3'd0, s2.rd, MAJ_JALR};
            end
            CLS_CALL: begin
                enc0 = {s2.hi, REG_RA, MAJ_AUIPC};
                enc1 = {s2.lo, REG_RA, 3'd0, REG_RA, MAJ_JALR};
                pair = 1'b1;
            end
            CLS_TAIL: begin
                enc0 = {s2.hi, REG_T1, MAJ_AUIPC};
                enc1 = {s2.lo, REG_T1, 3'd0, REG_ZERO, MAJ_JALR};
                pair = 1'b1;
            end
            CLS_LI: begin
                enc0 = {s2.hi, s2.rd, MAJ_LUI};
                enc1 = {s2.lo, s2.rd, 3'd0, s2.rd, MAJ_IMM};
                pair = 1'b1;
            end
            CLS_LUI: begin
                enc0 = {s2.imm[19:0], s2.rd, MAJ_LUI};
            end
            CLS_AUIPC: begin
                enc0 = {s2.imm[19:0], s2.rd, MAJ_AUIPC};
            end
            default: begin
                enc0 = '0;
            end
        endcase

        if (s2.err != ERR_NONE) begin
            word0 = '0;
            word1 = '0;
            two   = 1'b0;
        end else begin
            word0 = enc0;
            word1 = enc1;
            two   = pair;
        end
    end

endmodule
`default_nettype wire

FILE: src/rv32im_instruction_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM instruction encoder
// Turns one assembler item (mnemonic, registers, resolved immediate or
// target, and placement address) into one or two RV32IM machine words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one item per transfer.
//   The output channel (out_valid / out_stall) carries one result word per
//   transfer, with its error code and a flag on the last word of the item.
//   The block is a three-stage pipeline: the input register (distance and
//   operation class), the check register (range and alignment checks, hi/lo
//   split of the long immediates) and the output register (assembled words).
//   Words are offered from the output register. One item enters per cycle
//   while in_stall is low; an item that expands into two words (call, tail,
//   li) holds the output register for two transfers, so the next item waits
//   behind it. Mnemonic codes above the last defined one produce no result
//   and leave the pipeline at the input.
//   When the receiver stalls, every stage that holds an item keeps it, and
//   in_stall rises as soon as the input register cannot move on. Nothing is
//   dropped or repeated. Reset clears the valid bits of all stages; the
//   block accepts a transfer in the first cycle after reset.
// ----------------------------------------------------------------------------
module rv32im_instruction_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  opcode,
    input  wire logic [4:0]  dest_reg,
    input  wire logic [4:0]  src1_reg,
    input  wire logic [4:0]  src2_reg,
    input  wire logic [31:0] imm_value,
    input  wire logic [31:0] item_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      instr_word,
    output logic [1:0]       error_code,
    output logic             last_word
);
    import rvenc_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when the one after it is free.
    // The output stage is free when empty, or when its word leaves and it
    // is not the first word of a pair.
    // ------------------------------------------------------------------
    logic s1_vld_reg;
    logic s1_vld_next;
    logic s2_vld_reg;
    logic out_vld_reg;
    logic two_reg;
    logic out_free;
    logic s2_ready;
    logic s1_ready;
    logic in_take;
    logic out_take;

    assign out_take = out_vld_reg && !out_stall;
    assign out_free = !out_vld_reg || (out_take && !two_reg);
    assign s2_ready = !s2_vld_reg || out_free;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: classify the mnemonic and form target minus address.
    // ------------------------------------------------------------------
    cls_t        cls_in;
    logic        defined_in;
    logic [5:0]  s1_op_reg;
    logic [4:0]  s1_rd_reg;
    logic [4:0]  s1_rs1_reg;
    logic [4:0]  s1_rs2_reg;
    logic [31:0] s1_imm_reg;
    logic [31:0] s1_dist_reg;
    logic        s1_misal_reg;
    cls_t        s1_cls_reg;

    always_comb begin
        defined_in = (opcode <= OPC_AUIPC);
        priority if (opcode <= OPC_R_END) begin
            cls_in = CLS_R;
        end else if (opcode <= OPC_I_END) begin
            cls_in = CLS_IARITH;
        end else if (opcode <= OPC_L_END) begin
            cls_in = CLS_LOAD;
        end else if (opcode <= OPC_S_END) begin
            cls_in = CLS_STORE;
        end else if (opcode <= OPC_B_END) begin
            cls_in = CLS_BRANCH;
        end else if (opcode == OPC_JAL) begin
            cls_in = CLS_JAL;
        end else if (opcode == OPC_JALR) begin
            cls_in = CLS_JALR;
        end else if (opcode == OPC_CALL) begin
            cls_in = CLS_CALL;
        end else if (opcode == OPC_TAIL) begin
            cls_in = CLS_TAIL;
        end else if (opcode == OPC_LI) begin
            cls_in = CLS_LI;
        end else if (opcode == OPC_LUI) begin
            cls_in = CLS_LUI;
        end else begin
            cls_in = CLS_AUIPC;
        end
    end

    // Undefined mnemonics never become valid, so they vanish here.
    assign s1_vld_next = in_take ? defined_in : (s1_vld_reg && !s2_ready);

    always_ff @(posedge clk) begin
        if (in_take) begin
            s1_op_reg    <= opcode;
            s1_cls_reg   <= cls_in;
            s1_rd_reg    <= dest_reg;
            s1_rs1_reg   <= src1_reg;
            s1_rs2_reg   <= src2_reg;
            s1_imm_reg   <= imm_value;
            s1_dist_reg  <= imm_value - item_address;
            s1_misal_reg <= (item_address[1:0] != 2'b00);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: range and alignment checks, hi/lo split.
    // ------------------------------------------------------------------
    logic        range_err;
    logic        imm_fits12;
    logic [31:0] imm_adj;
    logic [31:0] split_val;
    s2_t         s2_next;
    s2_t         s2_reg;

    always_comb begin
        imm_fits12 = (s1_imm_reg[31:11] == {21{s1_imm_reg[11]}});
        unique case (s1_cls_reg)
            CLS_IARITH: begin
                if (s1_op_reg == OPC_SLLI || s1_op_reg == OPC_SRLI ||
                    s1_op_reg == OPC_SRAI) begin
                    range_err = (s1_imm_reg[31:5] != '0);
                end else begin
                    range_err = !imm_fits12;
                end
            end
            CLS_LOAD, CLS_STORE, CLS_JALR: range_err = !imm_fits12;
            CLS_BRANCH: range_err = (s1_dist_reg[31:12] != {20{s1_dist_reg[12]}});
            CLS_JAL:    range_err = (s1_dist_reg[31:20] != {12{s1_dist_reg[20]}});
            CLS_LUI, CLS_AUIPC: range_err = (s1_imm_reg[31:20] != '0);
            default:    range_err = 1'b0;
        endcase

        // The arithmetic right shift carries its funct7 bit in the immediate.
        imm_adj = s1_imm_reg;
        if (s1_op_reg == OPC_SRAI) begin
            imm_adj[10] = 1'b1;
        end

        // li splits the immediate; call and tail split the distance.
        split_val = (s1_cls_reg == CLS_LI) ? s1_imm_reg : s1_dist_reg;

        s2_next.cls    = s1_cls_reg;
        s2_next.opcode = s1_op_reg;
        s2_next.rd     = s1_rd_reg;
        s2_next.rs1    = s1_rs1_reg;
        s2_next.rs2    = s1_rs2_reg;
        s2_next.imm    = imm_adj;
        s2_next.disp   = s1_dist_reg;
        s2_next.hi     = split_val[31:12] + {19'd0, split_val[11]};
        s2_next.lo     = split_val[11:0];
        if (s1_misal_reg) begin
            s2_next.err = ERR_ALIGN;
        end else if (range_err) begin
            s2_next.err = ERR_RANGE;
        end else begin
            s2_next.err = ERR_NONE;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_vld_reg && s2_ready) begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: word assembly into the output register. The second word of
    // a pair waits in word1_reg and moves up after the first transfer.
    // ------------------------------------------------------------------
    logic [31:0] asm_word0;
    logic [31:0] asm_word1;
    logic        asm_two;
    logic [31:0] word_reg;
    logic [31:0] word1_reg;
    logic [1:0]  err_reg;

    rvenc_pack u_pack (
        .s2    (s2_reg),
        .word0 (asm_word0),
        .word1 (asm_word1),
        .two   (asm_two)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            two_reg     <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            if (s2_ready) begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_free) begin
                out_vld_reg <= s2_vld_reg;
                two_reg     <= s2_vld_reg && asm_two;
            end else if (out_take) begin
                two_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (out_free && s2_vld_reg) begin
            word_reg  <= asm_word0;
            word1_reg <= asm_word1;
            err_reg   <= s2_reg.err;
        end else if (out_take && two_reg) begin
            word_reg <= word1_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign instr_word = word_reg;
    assign error_code = err_reg;
    assign last_word  = !two_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An error result is always a single word.
    a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && two_reg |-> err_reg == ERR_NONE)
        else $error("two-word result carries an error code");

    // After the first word of a pair leaves, its last word is offered next.
    a_pair_follows : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=> out_valid && last_word)
        else $error("second word of a pair did not follow the first");

    // An error result carries a zero word.
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> instr_word == 32'd0)
        else $error("error result with a nonzero word");

    // A held pair blocks the next item from entering the output register.
    a_pair_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && two_reg |-> !out_free)
        else $error("output register freed while a word is pending");

endmodule
`default_nettype wire
